// ----- hw/rtl/rme_pkg.sv -----
// Package for the RSA modular exponentiation engine.
// Holds widths, config register indexes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rme_pkg;

  localparam int MOD_BITS = 32;
  localparam int EXP_BITS = 32;
  localparam int VALUE_W  = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam int CNT_MAX = (MOD_BITS > VALUE_W) ? MOD_BITS : VALUE_W;
  localparam int CNT_W   = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;
  localparam int ECNT_W  = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS  = 2'd0,
    REG_PUB_EXP  = 2'd1,
    REG_PRIV_EXP = 2'd2
  } cfg_reg_t;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic load;
    logic red_step;
    logic mul_init;
    logic mul_sel_base;
    logic mul_step;
    logic mul_write;
    logic exp_shift;
    logic publish;
  } rme_cmd_t;

  typedef struct packed {
    logic exp_msb;
  } rme_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rme_if.sv -----
// Stream interfaces for input and result words of the exponentiation engine.
// Depends on rme_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rme_in_if;
  import rme_pkg::*;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [VALUE_W-1:0] value_in;
  logic               last_in;

  modport source (output valid, opcode, value_in, last_in, input ready);
  modport sink   (input valid, opcode, value_in, last_in, output ready);
endinterface

interface rme_out_if;
  import rme_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value_out;
  logic               last_out;

  modport source (output valid, value_out, last_out, input ready);
  modport sink   (input valid, value_out, last_out, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rme_datapath.sv -----
// Datapath: base reduction by shift-subtract, bit-serial modular multiply,
// exponent shift register and result register. Depends on rme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rme_datapath (
  input  wire logic                     clk,
  input  wire rme_pkg::rme_cmd_t        cmd,
  output rme_pkg::rme_sts_t             sts,
  input  wire logic [rme_pkg::MOD_BITS-1:0] modulus,
  input  wire logic [rme_pkg::EXP_BITS-1:0] exponent,
  input  wire logic [rme_pkg::VALUE_W-1:0]  value_in,
  input  wire logic                     last_in,
  output logic [rme_pkg::VALUE_W-1:0]   value_out,
  output logic                          last_out
);
  import rme_pkg::*;

  logic [MOD_BITS-1:0] m;
  logic [EXP_BITS-1:0] e;
  logic [VALUE_W-1:0]  q;
  logic [MOD_BITS-1:0] rem;   // holds the reduced base after the reduce phase
  logic [MOD_BITS-1:0] r;
  logic [MOD_BITS-1:0] acc;
  logic [MOD_BITS-1:0] mb;
  logic                last_q;

  logic [MOD_BITS:0]   mx;
  logic [MOD_BITS:0]   rem_sh;
  logic [MOD_BITS-1:0] rem_next;
  logic [MOD_BITS:0]   dbl;
  logic [MOD_BITS-1:0] dbl_r;
  logic [MOD_BITS:0]   sum;
  logic [MOD_BITS-1:0] sum_r;
  logic [MOD_BITS-1:0] acc_next;

  always_comb begin
    mx       = {1'b0, m};
    rem_sh   = {rem, q[VALUE_W-1]};
    rem_next = (rem_sh >= mx) ? MOD_BITS'(rem_sh - mx) : rem_sh[MOD_BITS-1:0];
    // acc = 2*acc mod m, then + r mod m when the multiplier bit is set
    dbl      = {acc, 1'b0};
    dbl_r    = (dbl >= mx) ? MOD_BITS'(dbl - mx) : dbl[MOD_BITS-1:0];
    sum      = {1'b0, dbl_r} + {1'b0, r};
    sum_r    = (sum >= mx) ? MOD_BITS'(sum - mx) : sum[MOD_BITS-1:0];
    acc_next = mb[MOD_BITS-1] ? sum_r : dbl_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m      <= modulus;
      e      <= exponent;
      q      <= value_in;
      rem    <= '0;
      r      <= (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
      last_q <= last_in;
    end
    if (cmd.red_step) begin
      rem <= rem_next;
      q   <= q << 1;
    end
    if (cmd.mul_init) begin
      acc <= '0;
      mb  <= cmd.mul_sel_base ? rem : r;
    end
    if (cmd.mul_step) begin
      acc <= acc_next;
      mb  <= mb << 1;
    end
    if (cmd.mul_write) begin
      r <= acc;
    end
    if (cmd.exp_shift) begin
      e <= e << 1;
    end
    if (cmd.publish) begin
      value_out <= (m == '0) ? '0 : VALUE_W'(r);
      last_out  <= last_q;
    end
  end

  assign sts.exp_msb = e[EXP_BITS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/rme_ctrl.sv -----
// Controller: sequences reduce, square and multiply phases for one word and
// owns the handshake flags. Depends on rme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rme_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire rme_pkg::rme_sts_t sts,
  output rme_pkg::rme_cmd_t      cmd
);
  import rme_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_INIT,
    S_RUN,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  cnt;
  logic [ECNT_W-1:0] ecnt;
  logic              is_sq;
  logic              accept;
  logic              slot_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:   cmd.load = accept;
      S_REDUCE: cmd.red_step = 1'b1;
      S_INIT: begin
        cmd.mul_init     = 1'b1;
        cmd.mul_sel_base = !is_sq;
      end
      S_RUN:    cmd.mul_step = 1'b1;
      S_WRITE: begin
        cmd.mul_write = 1'b1;
        // exponent bit is consumed once no multiply by the base remains
        cmd.exp_shift = !(is_sq && sts.exp_msb);
      end
      S_FINISH: cmd.publish = slot_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ecnt      <= '0;
      is_sq     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (cnt == CNT_W'(VALUE_W - 1)) begin
            ecnt  <= '0;
            is_sq <= 1'b1;
            state <= S_INIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_INIT: begin
          cnt   <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          if (cnt == CNT_W'(MOD_BITS - 1)) state <= S_WRITE;
          else cnt <= cnt + 1'b1;
        end
        S_WRITE: begin
          if (is_sq && sts.exp_msb) begin
            is_sq <= 1'b0;
            state <= S_INIT;
          end else if (ecnt == ECNT_W'(EXP_BITS - 1)) begin
            state <= S_FINISH;
          end else begin
            ecnt  <= ecnt + 1'b1;
            is_sq <= 1'b1;
            state <= S_INIT;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rsa_modexp_engine.sv -----
// Work per word: the reduce phase, then the bit-serial modular multiplier, run once
//   per square and once per set exponent bit, then the result is published.
// Throughput: one word at a time; a new word is taken while the previous
//   result waits in the output register.
// Reset (rst, synchronous): modulus = 1, both exponents = 0, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module rsa_modexp_engine (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [rme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rme_pkg::CFG_W-1:0]     cfg_data,
  rme_in_if.sink                            in_ch,
  rme_out_if.source                         out_ch
);
  import rme_pkg::*;

  logic [MOD_BITS-1:0] modulus;
  logic [EXP_BITS-1:0] public_exponent;
  logic [EXP_BITS-1:0] private_exponent;
  logic [EXP_BITS-1:0] exp_sel;
  rme_cmd_t            cmd;
  rme_sts_t            sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= MOD_BITS'(1);
      public_exponent  <= '0;
      private_exponent <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS:  modulus          <= MOD_BITS'(cfg_data);
        REG_PUB_EXP:  public_exponent  <= EXP_BITS'(cfg_data);
        REG_PRIV_EXP: private_exponent <= EXP_BITS'(cfg_data);
        default:      ;
      endcase
    end
  end

  assign exp_sel = (in_ch.opcode == OP_DECRYPT) ? private_exponent : public_exponent;

  rme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rme_datapath u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .sts       (sts),
    .modulus   (modulus),
    .exponent  (exp_sel),
    .value_in  (in_ch.value_in),
    .last_in   (in_ch.last_in),
    .value_out (out_ch.value_out),
    .last_out  (out_ch.last_out)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second word taken while one is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten before it was taken");

  a_reduced: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (modulus != '0) |-> (MOD_BITS'(out_ch.value_out) < modulus))
    else $error("result not reduced below modulus");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(cmd.red_step || cmd.mul_step || cmd.publish))
    else $error("load overlaps an active phase");

endmodule

`default_nettype wire

// ----- tb/sv/tb_rsa_modexp_engine.sv -----
// Testbench for rsa_modexp_engine: drives words through the input stream, predicts
// value^exponent mod modulus per word and checks each result word in order.
// Depends on rme_pkg, rme_in_if/rme_out_if and the engine RTL.
`timescale 1ns / 1ps

module tb_rsa_modexp_engine;
  import rme_pkg::*;

  // the index range has one code past the register list; writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } power_word_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  rme_in_if  in_ch ();
  rme_out_if out_ch ();

  rsa_modexp_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // shadow copy of the key registers
  logic [CFG_W-1:0] modulus_cfg;
  logic [CFG_W-1:0] pub_exp_cfg;
  logic [CFG_W-1:0] priv_exp_cfg;

  power_word_t pending_powers[$];
  int          error_count   = 0;
  int          send_idle_pct = 14;
  int          recv_idle_pct = 75;

  always #1 clk = ~clk;

  function automatic logic [VALUE_W-1:0] modexp_predict(logic [VALUE_W-1:0] base,
                                                        logic [EXP_BITS-1:0] expo,
                                                        logic [MOD_BITS-1:0] m);
    longint unsigned mm;
    longint unsigned b;
    longint unsigned acc;
    if (m == '0) return '0;
    mm  = m;
    b   = base % mm;
    acc = 1 % mm;
    for (int i = EXP_BITS - 1; i >= 0; i--) begin
      acc = (acc * acc) % mm;
      if (expo[i]) acc = (acc * b) % mm;
    end
    return acc[VALUE_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // result side: random backpressure, in-order compare
  always @(posedge clk) begin
    power_word_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_powers.size() == 0) begin
          report_mismatch($sformatf("unexpected word value=%h last=%b",
                                    out_ch.value_out, out_ch.last_out));
        end else begin
          want = pending_powers.pop_front();
          if (out_ch.value_out !== want.value)
            report_mismatch($sformatf("value_out got %h want %h",
                                      out_ch.value_out, want.value));
          if (out_ch.last_out !== want.last)
            report_mismatch($sformatf("last_out got %b want %b",
                                      out_ch.last_out, want.last));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // valid stays high after acceptance unless the next call idles or the stream drains
  task automatic send_word(input logic op, input logic [VALUE_W-1:0] val, input logic lst);
    power_word_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.value_in <= val;
    in_ch.last_in  <= lst;
    do @(posedge clk); while (!in_ch.ready);
    want.value = modexp_predict(val, (op == OP_DECRYPT) ? priv_exp_cfg : pub_exp_cfg,
                                modulus_cfg);
    want.last  = lst;
    pending_powers.push_back(want);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
  endtask

  // only called with the engine idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_MODULUS:  modulus_cfg  = data;
      REG_PUB_EXP:  pub_exp_cfg  = data;
      REG_PRIV_EXP: priv_exp_cfg = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_keys(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] pub,
                            input logic [CFG_W-1:0] priv);
    write_reg(REG_MODULUS, m);
    write_reg(REG_PUB_EXP, pub);
    write_reg(REG_PRIV_EXP, priv);
  endtask

  function automatic logic [CFG_W-1:0] pick_exponent();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 1;
      2:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_modulus();
    case ($urandom_range(9))
      0:       return 1;
      1:       return '1;
      2:       return $urandom_range(255, 2);
      3:       return $urandom_range(65535, 256);
      default: return $urandom | 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(11))
      0:       return '0;
      1:       return 1;
      2:       return '1;
      3:       return modulus_cfg;
      4:       return modulus_cfg - 1;
      5:       return $urandom % ((modulus_cfg == 0) ? 1 : modulus_cfg);
      default: return $urandom;
    endcase
  endfunction

  // registers right out of reset: modulus 1 so every result is zero
  task automatic test_reset_keys();
    send_word(OP_ENCRYPT, 32'h1234_5678, 1'b0);
    send_word(OP_DECRYPT, '1, 1'b1);
    wait_drained();
  endtask

  task automatic test_corner_words();
    write_keys('1, '1, '0);
    send_word(OP_ENCRYPT, '0, 1'b0);
    send_word(OP_ENCRYPT, '1, 1'b1);
    send_word(OP_ENCRYPT, 32'hFFFF_FFFE, 1'b0);
    send_word(OP_DECRYPT, '1, 1'b1);          // zero exponent gives one
    send_word(OP_DECRYPT, 32'h1234_5678, 1'b0);
    wait_drained();
    write_reg(REG_PUB_EXP, 1);
    write_reg(REG_PRIV_EXP, '1);
    write_reg(REG_UNUSED, 32'h0000_0007);     // must leave the keys alone
    send_word(OP_ENCRYPT, '1, 1'b0);
    send_word(OP_ENCRYPT, 32'hDEAD_BEEF, 1'b1);
    send_word(OP_DECRYPT, 2, 1'b0);
    wait_drained();
    write_keys(32'h8000_0000, 2, 32'h8000_0001);
    send_word(OP_ENCRYPT, '1, 1'b1);
    send_word(OP_DECRYPT, 3, 1'b0);
    wait_drained();
  endtask

  // textbook key n = 61*53: encrypt then decrypt must round-trip
  task automatic test_small_key();
    write_keys(3233, 17, 2753);
    send_word(OP_ENCRYPT, 65, 1'b0);
    send_word(OP_DECRYPT, 2790, 1'b1);
    send_word(OP_ENCRYPT, 3233, 1'b0);
    send_word(OP_DECRYPT, '1, 1'b1);
    wait_drained();
    write_reg(REG_MODULUS, 2);
    send_word(OP_ENCRYPT, 3, 1'b0);
    send_word(OP_DECRYPT, 4, 1'b1);
    wait_drained();
    write_reg(REG_MODULUS, 0);                // no residue exists: result zero
    send_word(OP_ENCRYPT, 5, 1'b0);
    send_word(OP_DECRYPT, '1, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_keys(input int n_sets, input int n_words,
                                  input logic bool_pause);
    for (int s = 0; s < n_sets; s++) begin
      write_keys(pick_modulus(), pick_exponent(), pick_exponent());
      for (int k = 0; k < n_words; k++) begin
        if (bool_pause && k == n_words / 2) wait_drained();
        send_word($urandom_range(1), pick_value(), $urandom_range(1));
      end
      wait_drained();
    end
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_MODULUS;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.opcode <= OP_ENCRYPT;
    in_ch.value_in <= '0;
    in_ch.last_in  <= 1'b0;
    modulus_cfg  = 1;
    pub_exp_cfg  = '0;
    priv_exp_cfg = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_keys();
    test_corner_words();
    test_small_key();
    test_random_keys(3, 29, 1'b0);
    send_idle_pct = 75;
    recv_idle_pct = 14;
    test_random_keys(3, 29, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_keys(3, 29, 1'b1);

    wait_drained();
    repeat (2300) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d words outstanding", pending_powers.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
